>>> rtl/core/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the channel payload types, the front-to-back request type and byte-class constants.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
    localparam logic [20:0] SUPPLEMENTARY  = 21'h010000;
    localparam logic [15:0] HIGH_SURROGATE = 16'hD800;
    localparam logic [15:0] LOW_SURROGATE  = 16'hDC00;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_UNIT,
        TAIL_PAIR
    } t_tail;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
        logic        text_done;
    } t_out;

    // One request: repl_count replacement units, then an optional tail.
    typedef struct packed {
        logic [1:0]  repl_count;
        t_tail       tail;
        logic [20:0] tail_data;
        logic        end_of_text;
    } t_cmd;

endpackage

>>> rtl/core/u8u16_front.sv
// Front end of the transcoder: accepts bytes, tracks the open sequence and
// classifies each byte into at most one back-end request. Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  u8u16_pkg::t_in   i_in_data,
    output logic             o_in_ready,
    input  logic             i_full,
    output logic             o_push,
    output u8u16_pkg::t_cmd  o_cmd
);

    logic [20:0] r_pp;
    logic [2:0]  r_len;
    logic [1:0]  r_br;
    logic [20:0] n_pp;
    logic [2:0]  n_len;
    logic [1:0]  n_br;

    logic        w_accept;
    logic        w_cont;
    logic        w_fresh;
    logic [20:0] w_pp_shift;
    logic [1:0]  w_br_inc;
    logic [7:0]  w_b;

    assign w_b        = i_in_data.data_byte;
    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cont     = (w_b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG;
    assign w_pp_shift = {r_pp[14:0], w_b[5:0]};
    assign w_br_inc   = r_br + 2'd1;

    always_comb begin
        n_pp              = r_pp;
        n_len             = r_len;
        n_br              = r_br;
        w_fresh           = 1'b0;
        o_cmd.repl_count  = 2'd0;
        o_cmd.tail        = u8u16_pkg::TAIL_NONE;
        o_cmd.tail_data   = 21'd0;
        o_cmd.end_of_text = i_in_data.end_of_text;

        if (r_len != u8u16_pkg::SEQ_NONE) begin
            if (w_cont) begin
                if ({1'b0, w_br_inc} + 3'd1 >= r_len) begin
                    if (w_pp_shift < u8u16_pkg::SUPPLEMENTARY) begin
                        o_cmd.tail      = u8u16_pkg::TAIL_UNIT;
                        o_cmd.tail_data = w_pp_shift;
                    end else begin
                        o_cmd.tail      = u8u16_pkg::TAIL_PAIR;
                        o_cmd.tail_data = w_pp_shift - u8u16_pkg::SUPPLEMENTARY;
                    end
                    n_pp  = 21'd0;
                    n_len = u8u16_pkg::SEQ_NONE;
                    n_br  = 2'd0;
                end else if (i_in_data.end_of_text) begin
                    o_cmd.repl_count = w_br_inc + 2'd1;
                end else begin
                    n_pp = w_pp_shift;
                    n_br = w_br_inc;
                end
            end else begin
                o_cmd.repl_count = r_br + 2'd1;
                n_pp    = 21'd0;
                n_len   = u8u16_pkg::SEQ_NONE;
                n_br    = 2'd0;
                w_fresh = 1'b1;
            end
        end else begin
            w_fresh = 1'b1;
        end

        if (w_fresh) begin
            if (!w_b[7]) begin
                o_cmd.tail      = u8u16_pkg::TAIL_UNIT;
                o_cmd.tail_data = {13'd0, w_b};
            end else if ((w_b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
                n_len = u8u16_pkg::SEQ_TWO;
                n_pp  = {16'd0, w_b[4:0]};
                n_br  = 2'd0;
            end else if ((w_b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
                n_len = u8u16_pkg::SEQ_THREE;
                n_pp  = {17'd0, w_b[3:0]};
                n_br  = 2'd0;
            end else if ((w_b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
                n_len = u8u16_pkg::SEQ_FOUR;
                n_pp  = {18'd0, w_b[2:0]};
                n_br  = 2'd0;
            end else begin
                o_cmd.tail      = u8u16_pkg::TAIL_UNIT;
                o_cmd.tail_data = {5'd0, u8u16_pkg::REPLACEMENT};
            end
            // A lead byte that ends the text is reported as one broken sequence.
            if (w_b[7] && !w_cont && i_in_data.end_of_text
                    && o_cmd.tail == u8u16_pkg::TAIL_NONE) begin
                o_cmd.tail      = u8u16_pkg::TAIL_UNIT;
                o_cmd.tail_data = {5'd0, u8u16_pkg::REPLACEMENT};
            end
        end

        if (i_in_data.end_of_text) begin
            n_pp  = 21'd0;
            n_len = u8u16_pkg::SEQ_NONE;
            n_br  = 2'd0;
        end
    end

    assign o_push = w_accept
        && (o_cmd.repl_count != 2'd0 || o_cmd.tail != u8u16_pkg::TAIL_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp  <= 21'd0;
            r_len <= u8u16_pkg::SEQ_NONE;
            r_br  <= 2'd0;
        end else if (w_accept) begin
            r_pp  <= n_pp;
            r_len <= n_len;
            r_br  <= n_br;
        end
    end

`ifndef NO_ASSERTIONS
    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len == u8u16_pkg::SEQ_NONE |-> r_br == 2'd0 && r_pp == 21'd0)
        else $error("closed sequence holds stale state");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.end_of_text |=> r_len == u8u16_pkg::SEQ_NONE)
        else $error("sequence still open after end of text");
`endif

endmodule

>>> rtl/core/u8u16_fifo.sv
// Request queue between the transcoder front and back ends.
// Depends on u8u16_pkg for the request type.
`timescale 1ns / 1ps

module u8u16_fifo #(
    parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8u16_pkg::t_cmd  i_cmd,
    input  logic             i_pop,
    output u8u16_pkg::t_cmd  o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    assign o_head  = r_mem[r_rd];
    assign o_empty = r_count == CNT_W'(0);
    assign o_full  = r_count == CNT_W'(DEPTH);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request queue read while empty");
`endif

endmodule

>>> rtl/core/u8u16_back.sv
// Back end of the transcoder: expands each queued request into UTF-16 code
// units and holds them in the output register. Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u8u16_pkg::t_cmd  i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    output u8u16_pkg::t_out  o_out_data,
    input  logic             i_out_ready
);

    logic            r_valid;
    logic [1:0]      r_idx;
    u8u16_pkg::t_out r_data;
    logic            n_valid;
    logic [1:0]      n_idx;

    logic            w_take;
    logic            w_last;
    logic [2:0]      w_total;
    logic [1:0]      w_tail_count;
    logic [1:0]      w_pos;
    logic [15:0]     w_unit;

    assign w_take = (!r_valid || i_out_ready) && !i_empty;
    assign w_pos  = r_idx - i_head.repl_count;

    always_comb begin
        unique case (i_head.tail)
            u8u16_pkg::TAIL_NONE: w_tail_count = 2'd0;
            u8u16_pkg::TAIL_UNIT: w_tail_count = 2'd1;
            u8u16_pkg::TAIL_PAIR: w_tail_count = 2'd2;
            default:              w_tail_count = 2'd0;
        endcase
        w_total = {1'b0, i_head.repl_count} + {1'b0, w_tail_count};
        w_last  = {1'b0, r_idx} + 3'd1 == w_total;

        if (r_idx < i_head.repl_count) begin
            w_unit = u8u16_pkg::REPLACEMENT;
        end else if (i_head.tail == u8u16_pkg::TAIL_PAIR) begin
            if (w_pos == 2'd0) begin
                w_unit = u8u16_pkg::HIGH_SURROGATE | {5'd0, i_head.tail_data[20:10]};
            end else begin
                w_unit = u8u16_pkg::LOW_SURROGATE | {6'd0, i_head.tail_data[9:0]};
            end
        end else begin
            w_unit = i_head.tail_data[15:0];
        end
    end

    assign o_pop = w_take && w_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_take) begin
            n_idx   = w_last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data.code_unit   <= w_unit;
            r_data.last_of_run <= w_last;
            r_data.text_done   <= w_last && i_head.end_of_text;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

`ifndef NO_ASSERTIONS
    a_run_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd0 |-> !i_empty)
        else $error("request left the queue before all its units were sent");
`endif

endmodule

>>> rtl/core/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u8u16_front, u8u16_fifo and u8u16_back; depends on u8u16_pkg.
//
// The block takes one UTF-8 byte per cycle while the request queue is not
// full and returns UTF-16 code units on a valid/ready output channel;
// malformed input becomes U+FFFD and code points of 0x10000 and up become
// surrogate pairs. A byte that yields n units (up to four) is expanded by
// the back end one unit per cycle while the output is not stalled, and the
// request queue of QUEUE_DEPTH entries absorbs such bursts before the input
// stalls. A lead byte that opens a sequence yields no unit and sends no
// request to the back end. The first unit of a byte passes the request queue
// and then the back end's output register before it reaches the output.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top #(
    parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  u8u16_pkg::t_in   i_in_data,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output u8u16_pkg::t_out  o_out_data,
    input  logic             i_out_ready
);

    u8u16_pkg::t_cmd w_cmd;
    u8u16_pkg::t_cmd w_head;
    logic            w_push;
    logic            w_pop;
    logic            w_empty;
    logic            w_full;

    u8u16_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
